@@ design/disk_request_scheduler_defines.svh @@
// Assertion helpers used by the scheduler back end.
`ifndef DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define DISK_REQUEST_SCHEDULER_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define DRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DRS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/dsched_pkg.sv @@
package dsched_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_POSITION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISK_CYLINDERS = 2'd2;

   localparam logic [1:0] POLICY_FCFS = 2'd0;
   localparam logic [1:0] POLICY_SCAN = 2'd1;
   localparam logic [1:0] POLICY_LOOK = 2'd2;

   localparam logic [21:0] SEEK_MAX = 22'h3FFFFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef struct packed {
      logic [1:0]  policy_mode;
      logic [15:0] start_position;
      logic [16:0] disk_cylinders;
   } csr_type;

   typedef enum logic [1:0] {
      BK_LOAD,
      BK_SWEEP,
      BK_WAIT,
      BK_DECIDE
   } back_state_type;

   typedef enum logic {
      PH_HIGH,
      PH_LOW
   } phase_type;

endpackage

@@ design/dsched_front.sv @@
module dsched_front #(
   parameter  int CYLINDER_BITS = 16,
   localparam int RW = (CYLINDER_BITS < 16) ? CYLINDER_BITS : 16
) (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_request_cylinder,
   input  logic               req_last_request,
   input  dsched_pkg::csr_type csr,
   output logic               q_valid,
   output logic [RW+1:0]      q_data,
   input  logic               q_ready
);
   import dsched_pkg::*;

   logic [RW-1:0] cyl;
   logic [RW-1:0] start;
   logic          fcfs;
   logic          low;

   // classify against the start position; first come first served keeps everything high
   always_comb begin
      cyl  = req_request_cylinder[RW-1:0];
      start = csr.start_position[RW-1:0];
      fcfs = !(csr.policy_mode == POLICY_SCAN || csr.policy_mode == POLICY_LOOK);
      low  = !fcfs && (cyl < start);
   end

   assign q_data    = {req_last_request, low, cyl};
   assign q_valid   = req_valid;
   assign req_ready = q_ready;

endmodule

@@ design/dsched_fifo.sv @@
module dsched_fifo #(
   parameter int W = 18
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   import dsched_pkg::*;

   localparam int FW = QUEUE_PTR_W + 1;

   logic [W-1:0]           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]          fill_ff, fill_in;
   logic                   push, pop;

   always_comb begin
      in_ready  = (fill_ff != FW'(QUEUE_DEPTH));
      out_valid = (fill_ff != '0);
      out_data  = entries_ff[rd_ptr_ff];
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + FW'(push) - FW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ design/dsched_back.sv @@
`include "disk_request_scheduler_defines.svh"

module dsched_back #(
   parameter  int MAX_REQUESTS  = 32,
   parameter  int CYLINDER_BITS = 16,
   localparam int RW = (CYLINDER_BITS < 16) ? CYLINDER_BITS : 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  logic [RW+1:0]       q_data,
   input  dsched_pkg::csr_type csr,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_served_cylinder,
   output logic [21:0]         rsp_seek_total,
   output logic                rsp_end_visit,
   output logic                rsp_overflow,
   output logic                rsp_last_step
);
   import dsched_pkg::*;

   localparam int PW   = (CYLINDER_BITS < 17) ? CYLINDER_BITS : 17;
   localparam int IW   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNTW = $clog2(MAX_REQUESTS + 1);
   localparam int RCW  = $clog2(MAX_REQUESTS + 2);
   localparam int KW   = RW + IW;
   localparam longint CYL_LIMIT = (CYLINDER_BITS >= 17) ? 131072 : (64'd1 << CYLINDER_BITS);

   back_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;

   logic [RW:0]     store_ff [MAX_REQUESTS];
   logic [RW:0]     rdata_ff;
   logic            rd_valid_ff;
   logic [IW-1:0]   rd_idx_ff;
   logic [CNTW-1:0] count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic [IW-1:0]   addr_ff, addr_in;
   logic            first_ff, first_in;
   logic [KW-1:0]   prev_key_ff, prev_key_in;
   logic            best_found_ff, best_found_in;
   logic [KW-1:0]   best_key_ff, best_key_in;
   logic [RW-1:0]   best_cyl_ff, best_cyl_in;
   logic [PW-1:0]   head_ff, head_in;
   logic [21:0]     acc_ff, acc_in;
   logic [RCW-1:0]  emitted_ff, emitted_in;
   logic            out_valid_ff, out_valid_in;
   logic [15:0]     out_cyl_ff;
   logic [21:0]     out_seek_ff;
   logic            out_endv_ff, out_drop_ff, out_last_ff;

   logic            q_last, q_low;
   logic [RW-1:0]   q_cyl;
   logic            wr_en, rd_en;
   logic            scan, fcfs;
   logic [17:0]     cyl_ext, final_ext;
   logic [PW-1:0]   final_cyl;
   logic [IW-1:0]   last_addr;
   logic [RCW-1:0]  total;
   logic            rd_low;
   logic [RW-1:0]   rd_cyl;
   logic [KW-1:0]   rd_key;
   logic            eligible, better, take;
   logic            emit, emit_last, endv, finish, out_free;
   logic [PW-1:0]   target, diff;
   logic [22:0]     seek_sum;
   logic [21:0]     acc_sat;

   always_comb begin
      q_last = q_data[RW+1];
      q_low  = q_data[RW];
      q_cyl  = q_data[RW-1:0];
      scan   = (csr.policy_mode == POLICY_SCAN);
      fcfs   = !(scan || csr.policy_mode == POLICY_LOOK);

      // final cylinder: count of zero acts as one, larger counts clamp to the cylinder range
      cyl_ext = {1'b0, csr.disk_cylinders};
      if (cyl_ext == '0) begin
         final_ext = '0;
      end else if (cyl_ext > 18'(CYL_LIMIT)) begin
         final_ext = 18'(CYL_LIMIT) - 18'd1;
      end else begin
         final_ext = cyl_ext - 18'd1;
      end
      final_cyl = final_ext[PW-1:0];

      last_addr = IW'(count_ff - CNTW'(1));
      total     = RCW'(count_ff) + RCW'(scan);

      // candidate search on (key, index): ascending above start, descending below
      rd_low = rdata_ff[RW];
      rd_cyl = rdata_ff[RW-1:0];
      rd_key = {(fcfs ? {RW{1'b0}} : rd_cyl), rd_idx_ff};
      if (phase_ff == PH_HIGH) begin
         eligible = !rd_low && (first_ff || rd_key > prev_key_ff);
         better   = !best_found_ff || rd_key < best_key_ff;
      end else begin
         eligible = rd_low && (first_ff || rd_key < prev_key_ff);
         better   = !best_found_ff || rd_key > best_key_ff;
      end
      take = rd_valid_ff && eligible && better;

      out_free = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      addr_in       = addr_ff;
      first_in      = first_ff;
      prev_key_in   = prev_key_ff;
      best_found_in = best_found_ff;
      best_key_in   = best_key_ff;
      best_cyl_in   = best_cyl_ff;
      head_in       = head_ff;
      acc_in        = acc_ff;
      emitted_in    = emitted_ff;
      q_ready       = (state_ff == BK_LOAD);
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      emit          = 1'b0;
      endv          = 1'b0;
      finish        = 1'b0;
      target        = PW'(best_cyl_ff);

      if (take) begin
         best_found_in = 1'b1;
         best_key_in   = rd_key;
         best_cyl_in   = rd_cyl;
      end

      diff     = (target > head_ff) ? target - head_ff : head_ff - target;
      seek_sum = {1'b0, acc_ff} + 23'(diff);
      acc_sat  = (seek_sum > {1'b0, SEEK_MAX}) ? SEEK_MAX : seek_sum[21:0];
      emit_last = ((emitted_ff + RCW'(1)) == total);

      unique case (state_ff)
         BK_LOAD: begin
            if (q_valid) begin
               // drop when the store is full, but still honour the last mark
               if (count_ff < CNTW'(MAX_REQUESTS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNTW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (q_last) begin
                  head_in       = PW'(csr.start_position[RW-1:0]);
                  acc_in        = '0;
                  phase_in      = PH_HIGH;
                  first_in      = 1'b1;
                  emitted_in    = '0;
                  addr_in       = '0;
                  best_found_in = 1'b0;
                  state_in      = BK_SWEEP;
               end
            end
         end
         BK_SWEEP: begin
            rd_en = 1'b1;
            if (addr_ff == last_addr) begin
               state_in = BK_WAIT;
            end else begin
               addr_in = addr_ff + IW'(1);
            end
         end
         BK_WAIT: begin
            state_in = BK_DECIDE;
         end
         BK_DECIDE: begin
            priority if (best_found_ff) begin
               emit = out_free;
               if (out_free) begin
                  prev_key_in = best_key_ff;
                  first_in    = 1'b0;
               end
            end else if (phase_ff == PH_HIGH && scan) begin
               target = final_cyl;
               endv   = 1'b1;
               emit   = out_free;
               if (out_free) begin
                  phase_in = PH_LOW;
                  first_in = 1'b1;
               end
            end else if (phase_ff == PH_HIGH) begin
               phase_in      = PH_LOW;
               first_in      = 1'b1;
               addr_in       = '0;
               best_found_in = 1'b0;
               state_in      = BK_SWEEP;
            end else begin
               finish = 1'b1;
            end
         end
      endcase

      // the end visit target feeds the seek path; recompute after selection
      diff     = (target > head_ff) ? target - head_ff : head_ff - target;
      seek_sum = {1'b0, acc_ff} + 23'(diff);
      acc_sat  = (seek_sum > {1'b0, SEEK_MAX}) ? SEEK_MAX : seek_sum[21:0];

      if (emit) begin
         head_in    = target;
         acc_in     = acc_sat;
         emitted_in = emitted_ff + RCW'(1);
         if (emit_last) begin
            finish = 1'b1;
         end else begin
            addr_in       = '0;
            best_found_in = 1'b0;
            state_in      = BK_SWEEP;
         end
      end
      if (finish) begin
         count_in   = '0;
         dropped_in = 1'b0;
         state_in   = BK_LOAD;
      end

      out_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_LOAD;
         phase_ff      <= PH_HIGH;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         first_ff      <= 1'b1;
         best_found_ff <= 1'b0;
         emitted_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         first_ff      <= first_in;
         best_found_ff <= best_found_in;
         emitted_ff    <= emitted_in;
         rd_valid_ff   <= rd_en;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      prev_key_ff <= prev_key_in;
      best_key_ff <= best_key_in;
      best_cyl_ff <= best_cyl_in;
      head_ff     <= head_in;
      acc_ff      <= acc_in;
      rd_idx_ff   <= addr_ff;
      if (emit) begin
         out_cyl_ff  <= 16'(target);
         out_seek_ff <= acc_sat;
         out_endv_ff <= endv;
         out_drop_ff <= dropped_ff;
         out_last_ff <= emit_last;
      end
   end

   // request store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[count_ff[IW-1:0]] <= {q_low, q_cyl};
      end
      if (rd_en) begin
         rdata_ff <= store_ff[addr_ff];
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_served_cylinder = out_cyl_ff;
   assign rsp_seek_total      = out_seek_ff;
   assign rsp_end_visit       = out_endv_ff;
   assign rsp_overflow        = out_drop_ff;
   assign rsp_last_step       = out_last_ff;

   `DRS_ASSERT(a_drop_when_full, clock, reset, (q_valid && q_ready && count_ff == CNTW'(MAX_REQUESTS)) |=> dropped_ff, "full store did not flag a dropped request")
   `DRS_ASSERT(a_last_ends_batch, clock, reset, (emit && emit_last) |=> (state_ff == BK_LOAD && count_ff == '0), "batch not closed after its final result")
   `DRS_ASSERT(a_result_from_decide, clock, reset, $rose(rsp_valid) |-> $past(state_ff == BK_DECIDE), "result appeared outside the decision step")

endmodule

@@ design/disk_request_scheduler.sv @@
// Channel  Ports   Direction  Moves
// -------  ------  ---------  -------------------------------------------------
// req      req_*   in         one cylinder request, last_request closes a batch
// rsp      rsp_*   out        one head movement with running seek total
// csr      csr_*   in         register write: index and data, always ready
//
// Requests are taken one per cycle into a four-entry queue while it has room and
// are written into the request store while the scheduler loads; ordering runs
// once the last request arrives. Each result costs one sweep of the store (a read
// of every entry, then the wait and decide steps), with one extra sweep when look
// turns from the upper to the lower side. Reset is synchronous and clears control
// state only. A stalled result holds in the output register while the next sweep
// runs; while a batch is served the queue takes up to four requests of the next
// batch and then stalls the input.
module disk_request_scheduler #(
   parameter int MAX_REQUESTS  = 32,
   parameter int CYLINDER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [15:0]                        req_request_cylinder,
   input  logic                               req_last_request,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [15:0]                        rsp_served_cylinder,
   output logic [21:0]                        rsp_seek_total,
   output logic                               rsp_end_visit,
   output logic                               rsp_overflow,
   output logic                               rsp_last_step,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dsched_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsched_pkg::CSR_DATA_W-1:0]  csr_data
);
   import dsched_pkg::*;

   localparam int RW = (CYLINDER_BITS < 16) ? CYLINDER_BITS : 16;

   csr_type       csr_ff, csr_in;
   logic          fq_valid, fq_ready;
   logic [RW+1:0] fq_data;
   logic          bq_valid, bq_ready;
   logic [RW+1:0] bq_data;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POLICY_MODE:    csr_in.policy_mode    = csr_data[1:0];
            CSR_START_POSITION: csr_in.start_position = csr_data[15:0];
            CSR_DISK_CYLINDERS: csr_in.disk_cylinders = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.policy_mode    <= POLICY_FCFS;
         csr_ff.start_position <= '0;
         csr_ff.disk_cylinders <= 17'h10000;
      end else begin
         csr_ff <= csr_in;
      end
   end

   dsched_front #(
      .CYLINDER_BITS (CYLINDER_BITS)
   ) u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_request_cylinder (req_request_cylinder),
      .req_last_request     (req_last_request),
      .csr                  (csr_ff),
      .q_valid              (fq_valid),
      .q_data               (fq_data),
      .q_ready              (fq_ready)
   );

   dsched_fifo #(
      .W (RW + 2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   dsched_back #(
      .MAX_REQUESTS  (MAX_REQUESTS),
      .CYLINDER_BITS (CYLINDER_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (bq_valid),
      .q_ready             (bq_ready),
      .q_data              (bq_data),
      .csr                 (csr_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_served_cylinder (rsp_served_cylinder),
      .rsp_seek_total      (rsp_seek_total),
      .rsp_end_visit       (rsp_end_visit),
      .rsp_overflow        (rsp_overflow),
      .rsp_last_step       (rsp_last_step)
   );

endmodule

@@ verif/disk_request_scheduler_tb.sv @@
`timescale 1ns / 1ps

module disk_request_scheduler_tb;
   import dsched_pkg::*;

   localparam int MAX_REQ       = 32;
   localparam int RANDOM_GOAL   = 455;
   localparam int SETTLE_CYCLES = 100;
   localparam int RSP_HOLD      = 400;
   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam int MAX_REPORTS   = 200;

   localparam logic [1:0]             POLICY_SPARE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED   = 2'd3;

   typedef struct packed {
      logic [15:0] served_cylinder;
      logic [21:0] seek_total;
      logic        end_visit;
      logic        overflow;
      logic        last_step;
   } head_move_type;

   class seek_order_board;
      logic [1:0]    policy;
      logic [15:0]   start_cyl;
      logic [16:0]   cylinders;
      logic [15:0]   batch[$];
      bit            dropped;
      logic [15:0]   head;
      logic [21:0]   seek;
      head_move_type planned_moves[$];
      int            errors;
      int            moves_checked;
      int            batches;
      int            overflow_batches;
      int            end_visits;
      int            policy_batches[4];

      function new();
         policy    = POLICY_FCFS;
         start_cyl = '0;
         cylinders = 17'h10000;
         dropped   = 0;
         head      = '0;
         seek      = '0;
         errors    = 0;
         moves_checked = 0;
         batches   = 0;
         overflow_batches = 0;
         end_visits = 0;
         foreach (policy_batches[k]) policy_batches[k] = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_POLICY_MODE: policy = data[1:0];
            CSR_START_POSITION: begin
               start_cyl = data[15:0];
               head      = data[15:0];
            end
            CSR_DISK_CYLINDERS: cylinders = data;
            default: ;
         endcase
      endfunction

      function void move_head(logic [15:0] target, bit to_end);
         logic [22:0]   sum;
         head_move_type m;
         sum = seek + ((target > head) ? target - head : head - target);
         if (sum > SEEK_MAX)
            sum = SEEK_MAX;
         seek = sum[21:0];
         head = target;
         m.served_cylinder = target;
         m.seek_total      = seek;
         m.end_visit       = to_end;
         m.overflow        = dropped;
         m.last_step       = 1'b0;
         planned_moves.push_back(m);
      endfunction

      function void note_request(logic [15:0] cyl, bit last);
         logic [15:0]   order[MAX_REQ];
         logic [15:0]   v;
         logic [16:0]   end_cyl;
         head_move_type m;
         int            n;
         int            i;
         int            j;
         int            split;
         if (batch.size() < MAX_REQ)
            batch.push_back(cyl);
         else
            dropped = 1;
         if (!last)
            return;
         head = start_cyl;
         seek = '0;
         batches++;
         policy_batches[policy]++;
         if (dropped)
            overflow_batches++;
         n = batch.size();
         if (policy == POLICY_SCAN || policy == POLICY_LOOK) begin
            for (i = 0; i < n; i++) begin
               v = batch[i];
               j = i;
               while (j > 0 && order[j-1] > v) begin
                  order[j] = order[j-1];
                  j--;
               end
               order[j] = v;
            end
            split = 0;
            while (split < n && order[split] < start_cyl)
               split++;
            for (i = split; i < n; i++)
               move_head(order[i], 0);
            if (policy == POLICY_SCAN) begin
               // clamp the cylinder count to 1 .. 2^16 before taking the final one
               end_cyl = (cylinders == 0) ? 17'd1 : cylinders;
               if (end_cyl > 17'h10000)
                  end_cyl = 17'h10000;
               end_cyl = end_cyl - 17'd1;
               move_head(end_cyl[15:0], 1);
               end_visits++;
            end
            for (i = split - 1; i >= 0; i--)
               move_head(order[i], 0);
         end else begin
            for (i = 0; i < n; i++)
               move_head(batch[i], 0);
         end
         m = planned_moves.pop_back();
         m.last_step = 1'b1;
         planned_moves.push_back(m);
         batch.delete();
         dropped = 0;
         seek    = '0;
         head    = start_cyl;
      endfunction

      function void compare_field(string label, logic [21:0] want, logic [21:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         end
      endfunction

      function void check_move(head_move_type got);
         head_move_type want;
         if (planned_moves.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t ns: head move to %0d (seek %0d) with nothing expected",
                        $time, got.served_cylinder, got.seek_total);
            return;
         end
         want = planned_moves.pop_front();
         moves_checked++;
         compare_field("served_cylinder", want.served_cylinder, got.served_cylinder);
         compare_field("seek_total", want.seek_total, got.seek_total);
         compare_field("end_visit", want.end_visit, got.end_visit);
         compare_field("overflow", want.overflow, got.overflow);
         compare_field("last_step", want.last_step, got.last_step);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [15:0]            req_request_cylinder = '0;
   logic                   req_last_request = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [15:0]            rsp_served_cylinder;
   logic [21:0]            rsp_seek_total;
   logic                   rsp_end_visit;
   logic                   rsp_overflow;
   logic                   rsp_last_step;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   seek_order_board sb = new();
   int              items_sent = 0;
   int              cycle_count = 0;
   bit              rsp_hold_asked = 0;

   disk_request_scheduler dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_request_cylinder (req_request_cylinder),
      .req_last_request     (req_last_request),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_served_cylinder  (rsp_served_cylinder),
      .rsp_seek_total       (rsp_seek_total),
      .rsp_end_visit        (rsp_end_visit),
      .rsp_overflow         (rsp_overflow),
      .rsp_last_step        (rsp_last_step),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timed out with %0d head moves outstanding",
                  $time, sb.planned_moves.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_move(head_move_type'{rsp_served_cylinder, rsp_seek_total,
                                       rsp_end_visit, rsp_overflow, rsp_last_step});
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stalls, long ready runs now and then, and one long hold-off on request
   initial begin : rsp_pacer
      int n;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_asked) begin
            rsp_hold_asked = 0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD) @(posedge clock);
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(logic [15:0] cyl, bit last, bit paced);
      int gap;
      req_valid            <= 1'b1;
      req_request_cylinder <= cyl;
      req_last_request     <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cyl, last);
      items_sent++;
      gap = paced ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, wait for every planned move, then let the scheduler go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.planned_moves.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_cylinder();
      int r;
      int span;
      r = $urandom_range(0, 99);
      if (sb.cylinders == 0)
         span = 1;
      else if (sb.cylinders > 17'h10000)
         span = 65536;
      else
         span = int'(sb.cylinders);
      if (r < 6)
         return 16'h0000;
      if (r < 12)
         return 16'hFFFF;
      if (r < 25)
         return 16'(int'(sb.start_cyl) + int'($urandom_range(0, 8)) - 4);
      if (r < 55)
         return 16'($urandom_range(0, span - 1));
      return 16'($urandom);
   endfunction

   function automatic int pick_batch_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(1, 8);
      if (r < 85)
         return $urandom_range(9, 20);
      if (r < 95)
         return $urandom_range(21, 32);
      return $urandom_range(33, 40);
   endfunction

   task automatic send_batch(int count, bit paced);
      int i;
      for (i = 0; i < count; i++)
         send_request(pick_cylinder(), i == count - 1, paced);
   endtask

   task automatic shuffle_config(bit every_reg);
      int                    r;
      logic [CSR_DATA_W-1:0] data;
      if (every_reg || $urandom_range(0, 2) != 0) begin
         r    = $urandom_range(0, 99);
         data = (r < 10) ? 17'(POLICY_SPARE) : 17'($urandom_range(0, 2));
         if ($urandom_range(0, 3) == 0)
            data[16:2] = 15'($urandom);
         write_csr(CSR_POLICY_MODE, data);
      end
      if (every_reg || $urandom_range(0, 2) != 0) begin
         r = $urandom_range(0, 99);
         if (r < 15)
            data = 17'h00000;
         else if (r < 30)
            data = 17'h0FFFF;
         else
            data = 17'($urandom_range(0, 65535));
         data[16] = 1'($urandom_range(0, 1));
         write_csr(CSR_START_POSITION, data);
      end
      if (every_reg || $urandom_range(0, 2) != 0) begin
         r = $urandom_range(0, 99);
         if (r < 8)
            data = 17'd0;
         else if (r < 16)
            data = 17'd1;
         else if (r < 30)
            data = 17'h10000;
         else if (r < 40)
            data = 17'($urandom_range(65537, 131071));
         else if (r < 60)
            data = 17'($urandom_range(2, 400));
         else
            data = 17'($urandom_range(1, 65536));
         write_csr(CSR_DISK_CYLINDERS, data);
      end
      if ($urandom_range(0, 19) == 0)
         write_csr(CSR_UNUSED, 17'($urandom));
   endtask

   initial begin : stimulus
      int  b;
      int  n_batches;
      int  phase;
      bit  pressure_done;
      phase = 0;
      pressure_done = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // arrival order across the full cylinder range
      write_csr(CSR_POLICY_MODE, 17'(POLICY_FCFS));
      write_csr(CSR_START_POSITION, 17'h08000);
      write_csr(CSR_DISK_CYLINDERS, 17'h10000);
      send_request(16'hFFFF, 0, 0);
      send_request(16'h0000, 0, 0);
      send_request(16'h8000, 1, 0);

      // scan on a short disk: request on the start, one beyond the final cylinder
      settle();
      write_csr(CSR_POLICY_MODE, 17'(POLICY_SCAN));
      write_csr(CSR_START_POSITION, 17'd100);
      write_csr(CSR_DISK_CYLINDERS, 17'd200);
      send_request(16'd150, 0, 0);
      send_request(16'd50, 0, 0);
      send_request(16'd100, 0, 0);
      send_request(16'd250, 0, 0);
      send_request(16'd0, 1, 0);

      // head already on the final cylinder, nothing below the start
      settle();
      write_csr(CSR_START_POSITION, 17'd199);
      send_request(16'd199, 1, 0);

      settle();
      write_csr(CSR_POLICY_MODE, 17'(POLICY_LOOK));
      write_csr(CSR_START_POSITION, 17'h01234);
      send_request(16'hFFFF, 0, 0);
      send_request(16'h0000, 0, 0);
      send_request(16'h1233, 0, 0);
      send_request(16'h1234, 1, 0);

      // spare policy code falls back to arrival order; unused index is ignored
      settle();
      write_csr(CSR_UNUSED, 17'h1FFFF);
      write_csr(CSR_POLICY_MODE, 17'h1FFFF);
      send_request(16'd7, 0, 0);
      send_request(16'd3, 1, 0);

      // zero cylinders acts as one; oversized count saturates
      settle();
      write_csr(CSR_POLICY_MODE, 17'(POLICY_SCAN));
      write_csr(CSR_START_POSITION, 17'h10000);
      write_csr(CSR_DISK_CYLINDERS, 17'd0);
      send_request(16'd5, 1, 0);
      settle();
      write_csr(CSR_DISK_CYLINDERS, 17'h1FFFF);
      send_request(16'd0, 1, 0);

      while (items_sent < RANDOM_GOAL) begin
         settle();
         shuffle_config(phase == 0);
         n_batches = $urandom_range(1, 4);
         for (b = 0; b < n_batches; b++)
            send_batch(pick_batch_size(), 1);
         if (!pressure_done && items_sent > 200) begin
            // stall the result side and keep the requests coming back to back
            rsp_hold_asked = 1;
            for (b = 0; b < 3; b++)
               send_batch($urandom_range(6, 12), 0);
            pressure_done = 1;
         end
         phase++;
      end

      settle();
      $display("Sent %0d requests in %0d batches over %0d settings; %0d head moves checked",
               items_sent, sb.batches, phase, sb.moves_checked);
      $display("Batches: %0d fcfs, %0d scan, %0d look, %0d spare code; %0d overflowed, %0d end visits",
               sb.policy_batches[POLICY_FCFS], sb.policy_batches[POLICY_SCAN],
               sb.policy_batches[POLICY_LOOK], sb.policy_batches[POLICY_SPARE],
               sb.overflow_batches, sb.end_visits);
      if (sb.errors == 0 && sb.planned_moves.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/dsched_pkg.sv
design/dsched_front.sv
design/dsched_fifo.sv
design/dsched_back.sv
design/disk_request_scheduler.sv
verif/disk_request_scheduler_tb.sv
